FILE: hdl/fbfl_pkg.sv
// Package for the fixed block free-list allocator: sizes, codes and FSM type.
`timescale 1ns / 1ps
package fbfl_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS  = 16384;
  localparam int BLOCK_BYTES = 4096;

  // Block address width and width of the in-use counter (holds 0..NUM_BLOCKS)
  localparam int ADDR_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

  // Port field widths
  localparam int CMD_W  = 1;
  localparam int IDX_W  = 14;
  localparam int STAT_W = 2;
  localparam int OFF_W  = 26;
  localparam int USE_W  = 15;

  // Width of the full index times block-size product
  localparam int PROD_W = ADDR_W + $clog2(BLOCK_BYTES) + 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Control states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD
  } state_t;

endpackage

FILE: hdl/fbfl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fixed_block_free_list_allocator_top.sv
// Top level of the fixed block free-list allocator.
`timescale 1ns / 1ps
// Fixed-size block pool allocator with a last-in-first-out free list.
// Request channel (req_valid/req_ready): command (0 = allocate, 1 = free)
// and block_index, which only a free uses. Response channel
// (rsp_valid/rsp_ready): status, granted_index, granted_offset and
// blocks_in_use, one response per request, in request order.
// A response appears in the output register the cycle after its request
// is taken. An allocate that leaves at least one block free occupies the
// block in ST_IDLE and then ST_LOAD, since the new head comes out of the
// link RAM's registered read port; every other request, the allocate of the
// last free block included, occupies it in ST_IDLE alone.
// Reset starts a clearing pass over all NUM_BLOCKS (16384) entries that
// writes link i - 1 into entry i, 0 into entry 0; req_ready stays low until it is done.
// After it the list holds every block, highest index on top, none in use.
// If the receiver holds rsp_ready low, the response stays registered and
// req_ready drops until it is taken; no request is lost or dropped.
module fixed_block_free_list_allocator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [fbfl_pkg::CMD_W-1:0]  command,
  input  logic [fbfl_pkg::IDX_W-1:0]  block_index,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [fbfl_pkg::STAT_W-1:0] status,
  output logic [fbfl_pkg::IDX_W-1:0]  granted_index,
  output logic [fbfl_pkg::OFF_W-1:0]  granted_offset,
  output logic [fbfl_pkg::USE_W-1:0]  blocks_in_use
);

  import fbfl_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  head;
  logic [CNT_W-1:0]   count;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_rdata;

  logic               accept;
  logic               is_alloc;
  logic               has_free;
  logic               last_block;
  logic               idx_ok;
  logic               free_ok;
  logic [PROD_W-1:0]  offset_prod;

  // Request decode
  assign accept     = req_valid && req_ready;
  assign is_alloc   = (command == CMD_ALLOC);
  assign has_free   = (count < CNT_W'(NUM_BLOCKS));
  assign last_block = ((count + CNT_W'(1)) == CNT_W'(NUM_BLOCKS));
  assign idx_ok     = (32'(block_index) < NUM_BLOCKS);
  assign free_ok    = (count != '0) && idx_ok;
  assign offset_prod = PROD_W'(head) * PROD_W'(BLOCK_BYTES);

  // Link memory
  fbfl_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head),
    .rdata (mem_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory control and handshake
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = (clr_addr == '0) ? '0 : clr_addr - ADDR_W'(1);
    mem_re     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == ADDR_W'(NUM_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        if (accept) begin
          if (is_alloc) begin
            // pop: fetch the link of the current head unless the list runs dry
            if (has_free && !last_block) begin
              mem_re     = 1'b1;
              state_next = ST_LOAD;
            end
          end else if (free_ok) begin
            // push: freed block links to the current head
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(block_index);
            mem_wdata = head;
          end
        end
      end
      ST_LOAD: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // List head and in-use count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= ADDR_W'(NUM_BLOCKS - 1);
      count <= '0;
    end else if (state == ST_LOAD) begin
      head <= mem_rdata;
    end else if (accept) begin
      if (is_alloc) begin
        if (has_free) begin
          count <= count + CNT_W'(1);
        end
      end else if (free_ok) begin
        head  <= ADDR_W'(block_index);
        count <= count - CNT_W'(1);
      end
    end
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= STAT_OK;
      granted_index  <= '0;
      granted_offset <= '0;
      blocks_in_use  <= USE_W'(count);
      if (is_alloc) begin
        if (has_free) begin
          granted_index  <= IDX_W'(head);
          granted_offset <= OFF_W'(offset_prod);
          blocks_in_use  <= USE_W'(count + CNT_W'(1));
        end else begin
          status <= STAT_EXHAUSTED;
        end
      end else if (count == '0) begin
        status <= STAT_UNDERFLOW;
      end else if (idx_ok) begin
        blocks_in_use <= USE_W'(count - CNT_W'(1));
      end
    end
  end

endmodule
